[src/mbfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbfs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int KS_W      = 31;

  // ratio ks / depth
  localparam int DIV_BITS  = KS_W + FRAC_BITS;
  localparam int REM_W     = DATA_W;

  // cube root of the ratio scaled by 2^(2F)
  localparam int RAD_W     = DIV_BITS + 2 * FRAC_BITS;
  localparam int ROOT_BITS = (RAD_W + 2) / 3;
  localparam int CUBE_W    = 3 * ROOT_BITS;

  // speed
  localparam int SQ_W      = 2 * DATA_W;
  localparam int SPD_BITS  = DATA_W;

  // coefficient
  localparam int GPROD_W   = ROOT_BITS + DATA_W;
  localparam int SCALED_W  = GPROD_W - FRAC_BITS;
  localparam int DIV_K     = 400;
  localparam int K_W       = 9;
  localparam int CF_W      = SCALED_W - (K_W - 1);

  // 400 = 16 * 25, the 25 by reciprocal multiply
  localparam int PRE_SH    = 4;
  localparam int QT_W      = SCALED_W - PRE_SH;
  localparam int RECIP_W   = 40;
  localparam int RECIP_SH  = 44;
  localparam logic [RECIP_W-1:0] RECIP_25 = 40'd703687441777;

  // friction and output
  localparam int MAG2_W    = 2 * DATA_W;
  localparam int FPROD_W   = CF_W + MAG2_W;
  localparam int DELTA_W   = 34;
  localparam int DIFF_W    = DELTA_W + 1;

  localparam logic signed [DATA_W-1:0] GRAVITY_RESET = 32'sd642908;
  localparam logic signed [DATA_W-1:0] DRY_RESET     = 32'sd3;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY       = 1'b0,
    REG_DRY_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [KS_W-1:0]          roughness;
    logic signed [DATA_W-1:0] u_vel;
    logic signed [DATA_W-1:0] v_vel;
    logic signed [DATA_W-1:0] water_depth;
    logic                     cell_wet;
    logic signed [DATA_W-1:0] x_source_in;
    logic signed [DATA_W-1:0] y_source_in;
  } cell_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_source_out;
    logic signed [DATA_W-1:0] y_source_out;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic                     active;
    logic                     u_neg;
    logic                     v_neg;
    logic [DATA_W-1:0]        umag;
    logic [DATA_W-1:0]        vmag;
    logic [SPD_BITS-1:0]      speed;
    logic signed [DATA_W-1:0] x_in;
    logic signed [DATA_W-1:0] y_in;
  } side_t;

endpackage

`default_nettype wire

[src/mbfs_ratio.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbfs_ratio
  import mbfs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_vld,
  input  cell_t                    cell_data,
  input  logic signed [DATA_W-1:0] dry_threshold,
  output logic                     out_vld,
  output logic [DIV_BITS-1:0]      quot,
  output side_t                    side
);

  localparam int SQX_W = SQ_W + 2;

  typedef struct packed {
    side_t               side;
    logic [DIV_BITS-1:0] num;
    logic [REM_W-2:0]    rem;
    logic [DATA_W-2:0]   den;
    logic [SQ_W-1:0]     sq;
    logic [SPD_BITS-1:0] sr;
    logic [SQ_W-1:0]     sr2;
  } step_t;

  logic                p0_vld;
  side_t               p0_side;
  logic [DIV_BITS-1:0] p0_num;
  logic [DATA_W-2:0]   p0_den;

  logic [DIV_BITS:0]   vld;
  step_t               st  [0:DIV_BITS];
  step_t               nxt [0:DIV_BITS-1];

  logic                act;
  side_t               side0;
  step_t               first;
  logic [SQ_W-1:0]     usq;
  logic [SQ_W-1:0]     vsq;

  always_comb begin
    act = cell_data.cell_wet && (cell_data.water_depth > dry_threshold) &&
          (cell_data.water_depth > 0);
    side0.active = act;
    side0.u_neg  = cell_data.u_vel[DATA_W-1];
    side0.v_neg  = cell_data.v_vel[DATA_W-1];
    side0.umag   = side0.u_neg ? DATA_W'(-cell_data.u_vel) : DATA_W'(cell_data.u_vel);
    side0.vmag   = side0.v_neg ? DATA_W'(-cell_data.v_vel) : DATA_W'(cell_data.v_vel);
    side0.speed  = '0;
    side0.x_in   = cell_data.x_source_in;
    side0.y_in   = cell_data.y_source_in;
  end

  always_comb begin
    usq = p0_side.umag * p0_side.umag;
    vsq = p0_side.vmag * p0_side.vmag;
    first.side = p0_side;
    first.num  = p0_num;
    first.rem  = '0;
    first.den  = p0_den;
    first.sq   = usq + vsq;
    first.sr   = '0;
    first.sr2  = '0;
  end

  // one quotient bit per stage, and one speed bit in each of the first SPD_BITS stages
  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] rem_sub;
    logic             take;
    logic [SQX_W-1:0] cand;
    logic             fits;
    for (int i = 0; i < DIV_BITS; i++) begin
      nxt[i]      = st[i];
      rem_sh      = {st[i].rem, st[i].num[DIV_BITS-1]};
      rem_sub     = rem_sh - {1'b0, st[i].den};
      take        = rem_sh >= {1'b0, st[i].den};
      nxt[i].num  = {st[i].num[DIV_BITS-2:0], take};
      nxt[i].rem  = take ? rem_sub[REM_W-2:0] : rem_sh[REM_W-2:0];
      cand        = '0;
      fits        = 1'b0;
      if (i < SPD_BITS) begin
        cand = SQX_W'(st[i].sr2) + (SQX_W'(st[i].sr) << (SPD_BITS - i))
             + (SQX_W'(1) << (2 * (SPD_BITS - 1 - i)));
        fits = cand <= SQX_W'(st[i].sq);
        if (fits) begin
          nxt[i].sr  = st[i].sr | (SPD_BITS'(1) << (SPD_BITS - 1 - i));
          nxt[i].sr2 = cand[SQ_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
      vld    <= '0;
    end else if (adv) begin
      p0_vld <= in_vld;
      vld    <= {vld[DIV_BITS-1:0], p0_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_side <= side0;
      p0_num  <= {cell_data.roughness, FRAC_BITS'(0)};
      p0_den  <= act ? cell_data.water_depth[DATA_W-2:0] : (DATA_W-1)'(1);
      st[0]   <= first;
      for (int i = 0; i < DIV_BITS; i++) begin
        st[i+1] <= nxt[i];
      end
    end
  end

  always_comb begin
    out_vld    = vld[DIV_BITS];
    quot       = st[DIV_BITS].num;
    side       = st[DIV_BITS].side;
    side.speed = st[DIV_BITS].sr;
  end

endmodule

`default_nettype wire

[src/mbfs_cbrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbfs_cbrt
  import mbfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic [DIV_BITS-1:0]  quot,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic [ROOT_BITS-1:0] root,
  output side_t                side
);

  localparam int CBX_W = CUBE_W + 2;
  localparam int SQR_W = 2 * ROOT_BITS;
  localparam int SQX_W = SQR_W + 2;

  typedef struct packed {
    side_t                side;
    logic [RAD_W-1:0]     n;
    logic [ROOT_BITS-1:0] r;
    logic [SQR_W-1:0]     r2;
    logic [CUBE_W-1:0]    r3;
  } step_t;

  logic [ROOT_BITS:0] vld;
  step_t              st  [0:ROOT_BITS];
  step_t              nxt [0:ROOT_BITS-1];

  // r, r^2 and r^3 are kept so each bit needs only shifts and adds
  always_comb begin
    int               b;
    logic [CBX_W-1:0] t1;
    logic [CBX_W-1:0] t2;
    logic [CBX_W-1:0] cand;
    logic [SQX_W-1:0] sq_c;
    logic             fits;
    for (int i = 0; i < ROOT_BITS; i++) begin
      b      = ROOT_BITS - 1 - i;
      nxt[i] = st[i];
      t1     = CBX_W'(st[i].r2) << b;
      t2     = CBX_W'(st[i].r) << (2 * b);
      cand   = CBX_W'(st[i].r3) + t1 + (t1 << 1) + t2 + (t2 << 1)
             + (CBX_W'(1) << (3 * b));
      fits   = cand <= CBX_W'(st[i].n);
      sq_c   = SQX_W'(st[i].r2) + (SQX_W'(st[i].r) << (b + 1))
             + (SQX_W'(1) << (2 * b));
      if (fits) begin
        nxt[i].r  = st[i].r | (ROOT_BITS'(1) << b);
        nxt[i].r2 = sq_c[SQR_W-1:0];
        nxt[i].r3 = cand[CUBE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ROOT_BITS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].side <= in_side;
      st[0].n    <= {quot, (2 * FRAC_BITS)'(0)};
      st[0].r    <= '0;
      st[0].r2   <= '0;
      st[0].r3   <= '0;
      for (int i = 0; i < ROOT_BITS; i++) begin
        st[i+1] <= nxt[i];
      end
    end
  end

  assign out_vld = vld[ROOT_BITS];
  assign root    = st[ROOT_BITS].r;
  assign side    = st[ROOT_BITS].side;

endmodule

`default_nettype wire

[src/mbfs_coef.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbfs_coef
  import mbfs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic [ROOT_BITS-1:0]     root,
  input  side_t                    in_side,
  input  logic signed [DATA_W-1:0] gravity,
  output logic                     out_vld,
  output logic [CF_W-1:0]          cf,
  output side_t                    side
);

  localparam int LO_W   = 20;
  localparam int PP_W   = 2 * LO_W;
  localparam int RSUM_W = QT_W + RECIP_W;

  logic [DATA_W-1:0]  gmag;
  logic               m_vld;
  side_t              m_side;
  logic [GPROD_W-1:0] m_prod;
  logic [QT_W-1:0]    m_qt;

  logic               d_vld;
  side_t              d_side;
  logic [PP_W-1:0]    d_ll;
  logic [PP_W-1:0]    d_lh;
  logic [PP_W-1:0]    d_hl;
  logic [PP_W-1:0]    d_hh;

  logic [RSUM_W-1:0]  rsum;

  assign gmag = gravity[DATA_W-1] ? DATA_W'(-gravity) : DATA_W'(gravity);
  assign m_qt = m_prod[GPROD_W-1:FRAC_BITS+PRE_SH];

  // divide by 400: shift by 4, then multiply by the reciprocal of 25
  assign rsum = RSUM_W'(d_ll) + (RSUM_W'(d_lh) << LO_W) + (RSUM_W'(d_hl) << LO_W)
              + (RSUM_W'(d_hh) << (2 * LO_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld   <= 1'b0;
      d_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      m_vld   <= in_vld;
      d_vld   <= m_vld;
      out_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side <= in_side;
      m_prod <= root * gmag;
      d_side <= m_side;
      d_ll   <= m_qt[LO_W-1:0] * RECIP_25[LO_W-1:0];
      d_lh   <= m_qt[LO_W-1:0] * RECIP_25[RECIP_W-1:LO_W];
      d_hl   <= m_qt[QT_W-1:LO_W] * RECIP_25[LO_W-1:0];
      d_hh   <= m_qt[QT_W-1:LO_W] * RECIP_25[RECIP_W-1:LO_W];
      side   <= d_side;
      cf     <= rsum[RSUM_W-1:RECIP_SH];
    end
  end

endmodule

`default_nettype wire

[src/mbfs_apply.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbfs_apply
  import mbfs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [CF_W-1:0] cf,
  input  side_t           in_side,
  output logic            out_vld,
  output result_t         result
);

  localparam int HALF_W = MAG2_W / 2;
  localparam int PP_W   = CF_W + HALF_W;
  localparam int SH_W   = FPROD_W - 2 * FRAC_BITS;

  localparam logic [DELTA_W-1:0] DELTA_CAP = {1'b1, (DELTA_W-1)'(0)};
  localparam logic signed [DIFF_W-1:0] MAXV =
    {{(DIFF_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] MINV =
    {{(DIFF_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic              a0_vld;
  side_t             a0_side;
  logic [CF_W-1:0]   a0_cf;
  logic [MAG2_W-1:0] a0_mu;
  logic [MAG2_W-1:0] a0_mv;

  logic              a1_vld;
  side_t             a1_side;
  logic [PP_W-1:0]   a1_ul;
  logic [PP_W-1:0]   a1_uh;
  logic [PP_W-1:0]   a1_vl;
  logic [PP_W-1:0]   a1_vh;

  logic               a2_vld;
  side_t              a2_side;
  logic [DELTA_W-1:0] a2_dx;
  logic [DELTA_W-1:0] a2_dy;

  logic [FPROD_W-1:0] fu;
  logic [FPROD_W-1:0] fv;
  logic [SH_W-1:0]    su;
  logic [SH_W-1:0]    sv;
  logic [DELTA_W-1:0] dx_next;
  logic [DELTA_W-1:0] dy_next;

  logic signed [DIFF_W-1:0] sdx;
  logic signed [DIFF_W-1:0] sdy;
  logic signed [DIFF_W-1:0] xd;
  logic signed [DIFF_W-1:0] yd;
  result_t                  result_next;

  always_comb begin
    fu      = (FPROD_W'(a1_uh) << HALF_W) + FPROD_W'(a1_ul);
    fv      = (FPROD_W'(a1_vh) << HALF_W) + FPROD_W'(a1_vl);
    su      = fu[FPROD_W-1:2*FRAC_BITS];
    sv      = fv[FPROD_W-1:2*FRAC_BITS];
    dx_next = (su > SH_W'(DELTA_CAP)) ? DELTA_CAP : su[DELTA_W-1:0];
    dy_next = (sv > SH_W'(DELTA_CAP)) ? DELTA_CAP : sv[DELTA_W-1:0];
  end

  always_comb begin
    sdx = '0;
    sdy = '0;
    if (a2_side.active) begin
      sdx = a2_side.u_neg ? -$signed({1'b0, a2_dx}) : $signed({1'b0, a2_dx});
      sdy = a2_side.v_neg ? -$signed({1'b0, a2_dy}) : $signed({1'b0, a2_dy});
    end
    xd = DIFF_W'(a2_side.x_in) - sdx;
    yd = DIFF_W'(a2_side.y_in) - sdy;
    result_next.saturated = 1'b0;
    if (xd > MAXV) begin
      result_next.x_source_out = MAXV[DATA_W-1:0];
      result_next.saturated    = 1'b1;
    end else if (xd < MINV) begin
      result_next.x_source_out = MINV[DATA_W-1:0];
      result_next.saturated    = 1'b1;
    end else begin
      result_next.x_source_out = xd[DATA_W-1:0];
    end
    if (yd > MAXV) begin
      result_next.y_source_out = MAXV[DATA_W-1:0];
      result_next.saturated    = 1'b1;
    end else if (yd < MINV) begin
      result_next.y_source_out = MINV[DATA_W-1:0];
      result_next.saturated    = 1'b1;
    end else begin
      result_next.y_source_out = yd[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a0_vld  <= 1'b0;
      a1_vld  <= 1'b0;
      a2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      a0_vld  <= in_vld;
      a1_vld  <= a0_vld;
      a2_vld  <= a1_vld;
      out_vld <= a2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_side <= in_side;
      a0_cf   <= cf;
      a0_mu   <= in_side.umag * in_side.speed;
      a0_mv   <= in_side.vmag * in_side.speed;
      a1_side <= a0_side;
      a1_ul   <= a0_cf * a0_mu[HALF_W-1:0];
      a1_uh   <= a0_cf * a0_mu[MAG2_W-1:HALF_W];
      a1_vl   <= a0_cf * a0_mv[HALF_W-1:0];
      a1_vh   <= a0_cf * a0_mv[MAG2_W-1:HALF_W];
      a2_side <= a1_side;
      a2_dx   <= dx_next;
      a2_dy   <= dy_next;
      result  <= result_next;
    end
  end

endmodule

`default_nettype wire

[src/manning_bed_friction_source.sv]
// channel  | handshake                  | payload
// cell     | cell_valid / cell_stall    | cell_data (cell_t)
// result   | result_valid / result_stall| result (result_t)
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one cell per cycle while cell_stall is low; pipeline depth follows the
// fraction bits, set by the bit-per-stage ratio divider and cube root chains
// all stages move together; result_stall on a held result freezes the pipe
// and raises cell_stall in the same cycle
// synchronous reset clears valids and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module manning_bed_friction_source
  import mbfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cell_valid,
  output logic                 cell_stall,
  input  cell_t                cell_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  logic signed [DATA_W-1:0] gravity;
  logic signed [DATA_W-1:0] dry_threshold;
  logic                     adv;

  logic                 r_vld;
  logic [DIV_BITS-1:0]  r_quot;
  side_t                r_side;
  logic                 c_vld;
  logic [ROOT_BITS-1:0] c_root;
  side_t                c_side;
  logic                 f_vld;
  logic [CF_W-1:0]      f_cf;
  side_t                f_side;

  assign adv        = !(result_valid && result_stall);
  assign cell_stall = !adv;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity       <= GRAVITY_RESET;
      dry_threshold <= DRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRAVITY:       gravity       <= cfg_data;
        REG_DRY_THRESHOLD: dry_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  mbfs_ratio u_ratio (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_vld        (cell_valid),
    .cell_data     (cell_data),
    .dry_threshold (dry_threshold),
    .out_vld       (r_vld),
    .quot          (r_quot),
    .side          (r_side)
  );

  mbfs_cbrt u_cbrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (r_vld),
    .quot    (r_quot),
    .in_side (r_side),
    .out_vld (c_vld),
    .root    (c_root),
    .side    (c_side)
  );

  mbfs_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (c_vld),
    .root    (c_root),
    .in_side (c_side),
    .gravity (gravity),
    .out_vld (f_vld),
    .cf      (f_cf),
    .side    (f_side)
  );

  mbfs_apply u_apply (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (f_vld),
    .cf      (f_cf),
    .in_side (f_side),
    .out_vld (result_valid),
    .result  (result)
  );

endmodule

`default_nettype wire

[src/mbfs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbfs_checker
  import mbfs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    cell_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    cell_stall |-> result_valid && result_stall)
    else $error("input stalled without a held result");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      result.x_source_out == SMAX || result.x_source_out == SMIN ||
      result.y_source_out == SMAX || result.y_source_out == SMIN)
    else $error("saturated flag without a clipped term");

endmodule

bind manning_bed_friction_source mbfs_checker u_chk (.*);

`default_nettype wire
